@@ sv/compartment_model_euler_step_assert.svh @@
// Assertion macros used by the block's top-level RTL file.
// Both sample on the rising clock edge and are off while reset is asserted.
`ifndef COMPARTMENT_MODEL_EULER_STEP_ASSERT_SVH
`define COMPARTMENT_MODEL_EULER_STEP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define CES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define CES_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ces_pkg.sv @@
`timescale 1ns / 1ps

package ces_pkg;

  // Population and rate formats
  localparam int unsigned FracBits = 16;
  localparam int unsigned PopW     = 32;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned BirthW   = 31;
  localparam int unsigned CountW   = 20;
  localparam int unsigned NumComp  = 5;

  // Multiplier: unsigned rate (or signed temp) times signed population
  localparam int unsigned OpAW  = CoefW + 1;
  localparam int unsigned OpBW  = PopW + 1;
  localparam int unsigned ProdW = OpAW + OpBW;
  // Chained term is a 64-bit product shifted right by FracBits
  localparam int unsigned TermW = 2 * PopW - FracBits;
  // Headroom for the exact sum of up to six terms
  localparam int unsigned AccW  = TermW + 3;

  localparam logic [CountW-1:0] CountMax = '1;

  // Rate register file
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = $clog2(NumRegs);
  localparam int unsigned CfgIdxW = RegIdxW + 1;

  localparam logic [RegIdxW-1:0] REG_CONVERSION = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] REG_INFECTION  = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] REG_DEATH      = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] REG_REVIVAL    = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] REG_TURNING    = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] REG_ISO_INF    = RegIdxW'(5);
  localparam logic [RegIdxW-1:0] REG_ISO_ZOM    = RegIdxW'(6);
  localparam logic [RegIdxW-1:0] REG_Q_LOSS     = RegIdxW'(7);

  // Compartment positions
  localparam int unsigned C_SUS = 0;
  localparam int unsigned C_INF = 1;
  localparam int unsigned C_ZOM = 2;
  localparam int unsigned C_REM = 3;
  localparam int unsigned C_QUA = 4;

  localparam logic [NumComp-1:0] M_NONE = '0;
  localparam logic [NumComp-1:0] M_S    = NumComp'(1) << C_SUS;
  localparam logic [NumComp-1:0] M_I    = NumComp'(1) << C_INF;
  localparam logic [NumComp-1:0] M_Z    = NumComp'(1) << C_ZOM;
  localparam logic [NumComp-1:0] M_R    = NumComp'(1) << C_REM;
  localparam logic [NumComp-1:0] M_Q    = NumComp'(1) << C_QUA;

  // Micro-op sequence of one Euler step
  localparam int unsigned OpW = 4;
  localparam logic [OpW-1:0] OP_BS   = OpW'(0);   // b*s, kept for bsz
  localparam logic [OpW-1:0] OP_AS   = OpW'(1);   // a*s, kept for asz
  localparam logic [OpW-1:0] OP_DS   = OpW'(2);
  localparam logic [OpW-1:0] OP_DI   = OpW'(3);
  localparam logic [OpW-1:0] OP_RI   = OpW'(4);
  localparam logic [OpW-1:0] OP_ZR   = OpW'(5);
  localparam logic [OpW-1:0] OP_KI   = OpW'(6);
  localparam logic [OpW-1:0] OP_TZ   = OpW'(7);
  localparam logic [OpW-1:0] OP_GQ   = OpW'(8);
  localparam logic [OpW-1:0] OP_BSZ  = OpW'(9);
  localparam logic [OpW-1:0] OP_ASZ  = OpW'(10);
  localparam logic [OpW-1:0] OP_LAST = OP_ASZ;

  typedef enum logic [1:0] {
    OPA_COEF,
    OPA_TMP_B,
    OPA_TMP_A
  } opa_sel_e;

  typedef enum logic [2:0] {
    POP_S,
    POP_I,
    POP_Z,
    POP_R,
    POP_Q
  } pop_sel_e;

  typedef enum logic [1:0] {
    SAVE_NONE,
    SAVE_B,
    SAVE_A
  } save_sel_e;

  typedef struct packed {
    opa_sel_e             opa;
    logic [RegIdxW-1:0]   coef;
    pop_sel_e             pop;
    save_sel_e            save;
    logic [NumComp-1:0]   add;
    logic [NumComp-1:0]   sub;
  } op_info_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic           init;
    logic           issue;
    logic [OpW-1:0] op;
  } ces_ctrl_t;

  function automatic op_info_t mk_op(input opa_sel_e opa, input logic [RegIdxW-1:0] coef,
                                     input pop_sel_e pop, input save_sel_e save,
                                     input logic [NumComp-1:0] add,
                                     input logic [NumComp-1:0] sub);
    op_info_t info;
    info.opa  = opa;
    info.coef = coef;
    info.pop  = pop;
    info.save = save;
    info.add  = add;
    info.sub  = sub;
    return info;
  endfunction

  // Operand selection and signs of each product in the update equations
  function automatic op_info_t op_info(input logic [OpW-1:0] op);
    op_info_t info;
    case (op)
      OP_BS:   info = mk_op(OPA_COEF,  REG_INFECTION,  POP_S, SAVE_B,    M_NONE, M_NONE);
      OP_AS:   info = mk_op(OPA_COEF,  REG_CONVERSION, POP_S, SAVE_A,    M_NONE, M_NONE);
      OP_DS:   info = mk_op(OPA_COEF,  REG_DEATH,      POP_S, SAVE_NONE, M_R,    M_S);
      OP_DI:   info = mk_op(OPA_COEF,  REG_DEATH,      POP_I, SAVE_NONE, M_R,    M_I);
      OP_RI:   info = mk_op(OPA_COEF,  REG_TURNING,    POP_I, SAVE_NONE, M_Z,    M_I);
      OP_ZR:   info = mk_op(OPA_COEF,  REG_REVIVAL,    POP_R, SAVE_NONE, M_Z,    M_R);
      OP_KI:   info = mk_op(OPA_COEF,  REG_ISO_INF,    POP_I, SAVE_NONE, M_Q,    M_I);
      OP_TZ:   info = mk_op(OPA_COEF,  REG_ISO_ZOM,    POP_Z, SAVE_NONE, M_Q,    M_Z);
      OP_GQ:   info = mk_op(OPA_COEF,  REG_Q_LOSS,     POP_Q, SAVE_NONE, M_R,    M_Q);
      OP_BSZ:  info = mk_op(OPA_TMP_B, REG_INFECTION,  POP_Z, SAVE_NONE, M_I,    M_S);
      OP_ASZ:  info = mk_op(OPA_TMP_A, REG_CONVERSION, POP_Z, SAVE_NONE, M_R,    M_Z);
      default: info = mk_op(OPA_COEF,  REG_CONVERSION, POP_S, SAVE_NONE, M_NONE, M_NONE);
    endcase
    return info;
  endfunction

  // Clamp an exact sum to the signed population range
  function automatic logic [PopW-1:0] sat_pop(input logic signed [AccW-1:0] v);
    logic [PopW-1:0] res;
    if (&v[AccW-1:PopW-1] || ~|v[AccW-1:PopW-1]) begin
      res = v[PopW-1:0];
    end else if (v[AccW-1]) begin
      res = {1'b1, {(PopW-1){1'b0}}};
    end else begin
      res = {1'b0, {(PopW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

@@ sv/compartment_model_euler_step.sv @@
// Five-compartment population model (susceptible, infected, zombie, removed,
// quarantined) advanced by forward Euler. An input transaction with tuser 0
// loads the five populations and clears the step count; it gives no result.
// A transaction with tuser 1 reports the step count and the populations as
// they stand, then applies one update with the birth inflow it carries. A
// step runs through the accepting cycle, then one shared 33x33 multiplier
// issued eleven times in turn (nine rate products and the two chained
// contact terms), a drain of the last product and a writeback; ready drops
// after acceptance and stays low until writeback completes. Writeback waits
// while an earlier result is still unaccepted on the output. Rates are
// unsigned Q0.32 already scaled by the time step, populations signed Q16.16
// saturated to the 32-bit range. Configuration is to be written by the user
// with the block idle; the block itself does not enforce this.
`timescale 1ns / 1ps

`include "compartment_model_euler_step_assert.svh"

module compartment_model_euler_step import ces_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Rate register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CoefW-1:0]    cfg_data_i,
  // Requests
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // init_susceptible, init_infected, init_zombie, init_removed,
  // init_quarantined, birth_inflow, one zero pad bit
  input  logic [191:0]        s_axis_tdata_i,
  // req_type
  input  logic [0:0]          s_axis_tuser_i,
  // Reports
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // step_count, out_susceptible, out_infected, out_zombie, out_removed,
  // out_quarantined, four zero pad bits
  output logic [183:0]        m_axis_tdata_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_WB    = 4'b1000
  } state_e;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam int unsigned OutW = CountW + NumComp * PopW;

  state_e                        state_d, state_q;
  logic [OpW-1:0]                op_cnt_d, op_cnt_q;
  logic [NumRegs-1:0][CoefW-1:0] coeff_q;
  logic [NumComp-1:0][PopW-1:0]  pop_d, pop_q;
  logic [NumComp-1:0][PopW-1:0]  init_pop;
  logic [NumComp-1:0][PopW-1:0]  next_pop;
  logic [CountW-1:0]             cnt_d, cnt_q;
  logic [OutW-1:0]               out_d, out_q;
  logic                          m_valid_d, m_valid_q;
  logic                          in_acc, load_acc, step_acc, out_free, wb_fire;
  logic [BirthW-1:0]             birth;
  ces_ctrl_t                     ctrl;

  // Field unpacking
  always_comb begin
    for (int k = 0; k < NumComp; k++) begin
      init_pop[k] = s_axis_tdata_i[k*PopW +: PopW];
    end
    birth = s_axis_tdata_i[NumComp*PopW +: BirthW];
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign load_acc = in_acc && (s_axis_tuser_i[0] == REQ_LOAD);
  assign step_acc = in_acc && (s_axis_tuser_i[0] == REQ_STEP);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign wb_fire  = (state_q == ST_WB) && out_free;

  // Rate registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else if (cfg_valid_i && cfg_index_i < CfgIdxW'(NumRegs)) begin
      coeff_q[cfg_index_i[RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    op_cnt_d = op_cnt_q;
    case (state_q)
      ST_IDLE: begin
        op_cnt_d = '0;
        if (step_acc) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        op_cnt_d = op_cnt_q + OpW'(1);
        if (op_cnt_q == OP_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_WB;
      ST_WB: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.init  = step_acc;
    ctrl.issue = (state_q == ST_MUL);
    ctrl.op    = op_cnt_q;
  end

  ces_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .coeff_i    (coeff_q),
    .pop_i      (pop_q),
    .birth_i    (birth),
    .next_pop_o (next_pop)
  );

  // Model state and report register
  always_comb begin
    pop_d     = pop_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    if (load_acc) begin
      pop_d = init_pop;
      cnt_d = '0;
    end else if (wb_fire) begin
      out_d     = {pop_q, cnt_q};
      m_valid_d = 1'b1;
      pop_d     = next_pop;
      if (cnt_q != CountMax) begin
        cnt_d = cnt_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_cnt_q  <= '0;
      pop_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_cnt_q  <= op_cnt_d;
      pop_q     <= pop_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q};

  `CES_ASSERT_NXT(a_step_starts_seq, step_acc, state_q == ST_MUL && op_cnt_q == '0, "step did not start the sequence")
  `CES_ASSERT_IMP(a_op_in_range, state_q == ST_MUL, op_cnt_q <= OP_LAST, "op counter ran past the last op")
  `CES_ASSERT_NXT(a_wb_reports, wb_fire, m_valid_q && state_q == ST_IDLE, "writeback gave no report")
  `CES_ASSERT_IMP(a_cnt_source, !$stable(cnt_q), $past(wb_fire) || $past(load_acc), "step count moved outside writeback or load")
  `CES_ASSERT_NXT(a_load_clears, load_acc, cnt_q == '0, "load did not clear step count")

endmodule

@@ sv/ces_mac.sv @@
`timescale 1ns / 1ps

// Shared multiplier with product register, two chain temporaries and five
// exact accumulators, one per compartment.
module ces_mac import ces_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ces_ctrl_t                        ctrl_i,
  input  logic [NumRegs-1:0][CoefW-1:0]    coeff_i,
  input  logic [NumComp-1:0][PopW-1:0]     pop_i,
  input  logic [BirthW-1:0]                birth_i,
  output logic [NumComp-1:0][PopW-1:0]     next_pop_o
);

  op_info_t                 info;
  op_info_t                 info_q;
  logic                     issue_q;
  logic signed [OpAW-1:0]   opa;
  logic signed [OpBW-1:0]   opb;
  logic signed [ProdW-1:0]  prod_d, prod_q;
  logic signed [PopW-1:0]   rate_term;
  logic signed [AccW-1:0]   term;
  logic signed [PopW-1:0]   tmp_a_d, tmp_a_q, tmp_b_d, tmp_b_q;
  logic signed [AccW-1:0]   acc_d [NumComp];
  logic signed [AccW-1:0]   acc_q [NumComp];

  assign info = op_info(ctrl_i.op);

  // Operand select and multiply
  always_comb begin
    case (info.opa)
      OPA_COEF:  opa = signed'({1'b0, coeff_i[info.coef]});
      OPA_TMP_B: opa = OpAW'(tmp_b_q);
      OPA_TMP_A: opa = OpAW'(tmp_a_q);
      default:   opa = '0;
    endcase
    opb    = OpBW'(signed'(pop_i[info.pop]));
    prod_d = opa * opb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
    end else begin
      issue_q <= ctrl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    info_q <= info;
  end

  // Rate product drops 32 fraction bits, chained product drops FracBits
  always_comb begin
    rate_term = signed'(prod_q[CoefW+PopW-1:CoefW]);
    if (info_q.opa != OPA_COEF) begin
      term = AccW'(signed'(prod_q[2*PopW-1:FracBits]));
    end else begin
      term = AccW'(rate_term);
    end
  end

  // Chain temporaries
  always_comb begin
    tmp_a_d = tmp_a_q;
    tmp_b_d = tmp_b_q;
    if (issue_q && info_q.save == SAVE_A) begin
      tmp_a_d = rate_term;
    end
    if (issue_q && info_q.save == SAVE_B) begin
      tmp_b_d = rate_term;
    end
  end

  // Accumulators: seeded with the old populations (susceptible plus birth inflow), then one term per cycle
  always_comb begin
    for (int k = 0; k < NumComp; k++) begin
      acc_d[k] = acc_q[k];
      if (ctrl_i.init) begin
        acc_d[k] = AccW'(signed'(pop_i[k]));
        if (k == C_SUS) begin
          acc_d[k] = AccW'(signed'(pop_i[k])) + AccW'(signed'({1'b0, birth_i}));
        end
      end else if (issue_q) begin
        if (info_q.add[k]) begin
          acc_d[k] = acc_d[k] + term;
        end
        if (info_q.sub[k]) begin
          acc_d[k] = acc_d[k] - term;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_a_q <= tmp_a_d;
    tmp_b_q <= tmp_b_d;
    for (int k = 0; k < NumComp; k++) begin
      acc_q[k] <= acc_d[k];
    end
  end

  always_comb begin
    for (int k = 0; k < NumComp; k++) begin
      next_pop_o[k] = sat_pop(acc_q[k]);
    end
  end

endmodule
